@@ src/blri_pkg.sv @@
// Shared types and constants for the battery level ratchet indicator.
// Used by blri_regs, blri_level, the top level, the checker and the testbench; depends on nothing.
package blri_pkg;

  localparam int unsigned THR_W   = 12;
  localparam int unsigned FLASH_W = 16;
  localparam int unsigned BLINK_W = 17;
  localparam int unsigned AVG_W   = 12;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]   THR_TEN_RST   = 12'd2600;
  localparam logic [THR_W-1:0]   THR_QTR_RST   = 12'd2800;
  localparam logic [THR_W-1:0]   THR_HALF_RST  = 12'd3000;
  localparam logic [THR_W-1:0]   THR_3Q_RST    = 12'd3200;
  localparam logic [THR_W-1:0]   THR_FULL_RST  = 12'd3400;
  localparam logic [FLASH_W-1:0] FLASH_LIM_RST = 16'd50;

  // Battery level codes; lower is emptier
  typedef enum logic [2:0] {
    LVL_DEAD    = 3'd0,
    LVL_TEN     = 3'd1,
    LVL_QUARTER = 3'd2,
    LVL_HALF    = 3'd3,
    LVL_3Q      = 3'd4,
    LVL_FULL    = 3'd5,
    LVL_UNKNOWN = 3'd6
  } level_e;

  // Register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_THR_TEN     = 3'd0,
    REG_THR_QUARTER = 3'd1,
    REG_THR_HALF    = 3'd2,
    REG_THR_3Q      = 3'd3,
    REG_THR_FULL    = 3'd4,
    REG_FLASH_LIMIT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]   thr_ten;
    logic [THR_W-1:0]   thr_quarter;
    logic [THR_W-1:0]   thr_half;
    logic [THR_W-1:0]   thr_three_quarter;
    logic [THR_W-1:0]   thr_full;
    logic [FLASH_W-1:0] flash_limit;
  } cfg_t;

endpackage

@@ src/blri_regs.sv @@
// APB configuration registers: band thresholds and blink flash limit.
// Depends on blri_pkg.
module blri_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [blri_pkg::ADDR_W-1:0]     paddr,
  input  logic [blri_pkg::DATA_W-1:0]     pwdata,
  output logic [blri_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output blri_pkg::cfg_t                  cfg_o
);

  blri_pkg::cfg_t   cfg_q;
  blri_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = blri_pkg::reg_idx_e'(paddr[blri_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_ten           <= blri_pkg::THR_TEN_RST;
      cfg_q.thr_quarter       <= blri_pkg::THR_QTR_RST;
      cfg_q.thr_half          <= blri_pkg::THR_HALF_RST;
      cfg_q.thr_three_quarter <= blri_pkg::THR_3Q_RST;
      cfg_q.thr_full          <= blri_pkg::THR_FULL_RST;
      cfg_q.flash_limit       <= blri_pkg::FLASH_LIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        blri_pkg::REG_THR_TEN:     cfg_q.thr_ten <= pwdata[blri_pkg::THR_W-1:0];
        blri_pkg::REG_THR_QUARTER: cfg_q.thr_quarter <= pwdata[blri_pkg::THR_W-1:0];
        blri_pkg::REG_THR_HALF:    cfg_q.thr_half <= pwdata[blri_pkg::THR_W-1:0];
        blri_pkg::REG_THR_3Q:      cfg_q.thr_three_quarter <= pwdata[blri_pkg::THR_W-1:0];
        blri_pkg::REG_THR_FULL:    cfg_q.thr_full <= pwdata[blri_pkg::THR_W-1:0];
        blri_pkg::REG_FLASH_LIMIT: cfg_q.flash_limit <= pwdata[blri_pkg::FLASH_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, unused addresses read zero
  always_comb begin
    unique case (idx)
      blri_pkg::REG_THR_TEN:     prdata = blri_pkg::DATA_W'(cfg_q.thr_ten);
      blri_pkg::REG_THR_QUARTER: prdata = blri_pkg::DATA_W'(cfg_q.thr_quarter);
      blri_pkg::REG_THR_HALF:    prdata = blri_pkg::DATA_W'(cfg_q.thr_half);
      blri_pkg::REG_THR_3Q:      prdata = blri_pkg::DATA_W'(cfg_q.thr_three_quarter);
      blri_pkg::REG_THR_FULL:    prdata = blri_pkg::DATA_W'(cfg_q.thr_full);
      blri_pkg::REG_FLASH_LIMIT: prdata = blri_pkg::DATA_W'(cfg_q.flash_limit);
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ src/blri_accum.sv @@
// Sample accumulator: sums SAMPLES_PER_CHECK samples and hands the total
// to the level stage through a one-entry register. Depends on nothing.
module blri_accum #(
  parameter int unsigned ADC_BITS          = 12,
  parameter int unsigned SAMPLES_PER_CHECK = 10,
  parameter int unsigned SUM_W             = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ADC_BITS-1:0] adc_sample_i,
  output logic                chk_valid_o,
  input  logic                chk_ready_i,
  output logic [SUM_W-1:0]    chk_sum_o
);

  localparam int unsigned CNT_W = (SAMPLES_PER_CHECK > 1) ? $clog2(SAMPLES_PER_CHECK) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_CHECK - 1);

  logic [SUM_W-1:0] sum_q, sum_d, total;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             chk_valid_q, chk_valid_d;
  logic [SUM_W-1:0] chk_sum_q;
  logic             accept, last;

  assign in_ready_o  = !chk_valid_q || chk_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign total       = sum_q + SUM_W'(adc_sample_i);
  assign last        = (cnt_q == LAST);
  assign chk_valid_o = chk_valid_q;
  assign chk_sum_o   = chk_sum_q;

  // running sum and sample count
  always_comb begin
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    chk_valid_d = chk_valid_q && !chk_ready_i;
    if (accept) begin
      if (last) begin
        sum_d       = '0;
        cnt_d       = '0;
        chk_valid_d = 1'b1;
      end else begin
        sum_d = total;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      chk_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      chk_valid_q <= chk_valid_d;
    end
  end

  // total of a completed check; payload only
  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      chk_sum_q <= total;
    end
  end

endmodule

@@ src/blri_level.sv @@
// Level stage: averages a check total, picks the band, ratchets the level,
// drives LED and fan-off state and holds the result register. Depends on blri_pkg.
module blri_level #(
  parameter int unsigned ADC_BITS          = 12,
  parameter int unsigned SAMPLES_PER_CHECK = 10,
  parameter int unsigned SUM_W             = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  blri_pkg::cfg_t                cfg_i,
  input  logic                          chk_valid_i,
  output logic                          chk_ready_o,
  input  logic [SUM_W-1:0]              chk_sum_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blri_pkg::AVG_W-1:0]    average_o,
  output logic [2:0]                    level_o,
  output logic                          led_a_o,
  output logic                          led_b_o,
  output logic                          led_c_o,
  output logic                          fan_off_o
);

  // compare width covers both the sample range and the 12-bit thresholds
  localparam int unsigned CMP_W = (ADC_BITS > blri_pkg::THR_W) ? ADC_BITS : blri_pkg::THR_W;

  // floor(x / N) as (x * ceil(2^SH / N)) >> SH, exact for every SUM_W-bit x
  localparam int unsigned DIV_SH  = SUM_W + $clog2(SAMPLES_PER_CHECK);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SH) +
      64'(SAMPLES_PER_CHECK) - 64'd1) / 64'(SAMPLES_PER_CHECK));

  logic [PROD_W-1:0]            prod;
  logic [SUM_W-1:0]             quot;
  logic [CMP_W-1:0]             avg;
  blri_pkg::level_e             band;
  blri_pkg::level_e             level_q, level_d;
  logic [2:0]                   led_q, led_d;      // bit0 a, bit1 b, bit2 c
  logic                         fan_q, fan_d;
  logic [blri_pkg::BLINK_W-1:0] blink_q, blink_d;
  logic                         out_valid_q;
  logic                         take;

  assign chk_ready_o = !out_valid_q || out_ready_i;
  assign take        = chk_valid_i && chk_ready_o;
  assign out_valid_o = out_valid_q;

  // floor average, reciprocal multiply by the constant divisor
  assign prod = PROD_W'(chk_sum_i) * PROD_W'(RECIP);
  assign quot = SUM_W'(prod >> DIV_SH);
  assign avg  = CMP_W'(quot);

  // band by priority, full first
  always_comb begin
    if (avg >= CMP_W'(cfg_i.thr_full))                band = blri_pkg::LVL_FULL;
    else if (avg >= CMP_W'(cfg_i.thr_three_quarter))  band = blri_pkg::LVL_3Q;
    else if (avg >= CMP_W'(cfg_i.thr_half))           band = blri_pkg::LVL_HALF;
    else if (avg >= CMP_W'(cfg_i.thr_quarter))        band = blri_pkg::LVL_QUARTER;
    else if (avg >= CMP_W'(cfg_i.thr_ten))            band = blri_pkg::LVL_TEN;
    else                                              band = blri_pkg::LVL_DEAD;
  end

  // ratchet down, LED pattern, then blink at ten percent
  always_comb begin
    level_d = level_q;
    led_d   = led_q;
    fan_d   = fan_q;
    blink_d = blink_q;
    if (level_q > band) begin
      level_d = band;
      case (band) inside
        blri_pkg::LVL_FULL: led_d = 3'b000;
        blri_pkg::LVL_3Q:   led_d = 3'b100;
        blri_pkg::LVL_HALF, blri_pkg::LVL_QUARTER: led_d = 3'b110;
        blri_pkg::LVL_TEN:  led_d = {2'b11, led_q[0]};
        default: begin
          led_d = 3'b111;
          fan_d = 1'b1;
        end
      endcase
    end
    if (level_d == blri_pkg::LVL_TEN) begin
      if (blink_q > blri_pkg::BLINK_W'(cfg_i.flash_limit)) begin
        led_d[0] = ~led_d[0];
        blink_d  = '0;
      end else begin
        blink_d = blink_q + blri_pkg::BLINK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= blri_pkg::LVL_UNKNOWN;
      led_q       <= '0;
      fan_q       <= 1'b0;
      blink_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        level_q <= level_d;
        led_q   <= led_d;
        fan_q   <= fan_d;
        blink_q <= blink_d;
      end
      out_valid_q <= take || (out_valid_q && !out_ready_i);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      average_o <= avg[blri_pkg::AVG_W-1:0];
      level_o   <= level_d;
      led_a_o   <= led_d[0];
      led_b_o   <= led_d[1];
      led_c_o   <= led_d[2];
      fan_off_o <= fan_d;
    end
  end

endmodule

@@ src/battery_level_ratchet_indicator_unit.sv @@
// Top level of the battery level ratchet indicator.
// Instantiates blri_regs, blri_accum and blri_level; depends on blri_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, adc_sample_i) takes one converter
//   sample per transaction. Every SAMPLES_PER_CHECK-th sample closes a check
//   and yields one result transaction on the output channel (out_valid_o/
//   out_ready_i): floor average, ratcheted level, three LED drives, fan-off.
//   Samples that do not close a check produce nothing.
//   Throughput: one sample per cycle while in_ready_o is high. The result of a
//   check passes from the closing sample into the accumulator hand-off
//   register, then through the average/band/ratchet logic into the result
//   register, from which it is offered on the output channel.
//   Stall: a pending result holds its payload while out_ready_i is low; one
//   further check total waits in the accumulator's hand-off register, and
//   in_ready_o drops only while that register is full and cannot move on.
//   Reset: sum and count cleared, level unknown, LEDs low, fan-off clear,
//   blink counter zero, registers at their default thresholds.
//   Configuration: APB, registers at byte offsets 0x00..0x14, pready tied high;
//   write only while no check is in flight.
module battery_level_ratchet_indicator_unit #(
  parameter int unsigned ADC_BITS          = 12,
  parameter int unsigned SAMPLES_PER_CHECK = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blri_pkg::ADDR_W-1:0]   paddr,
  input  logic [blri_pkg::DATA_W-1:0]   pwdata,
  output logic [blri_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ADC_BITS-1:0]           adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blri_pkg::AVG_W-1:0]    average_o,
  output logic [2:0]                    level_o,
  output logic                          led_a_o,
  output logic                          led_b_o,
  output logic                          led_c_o,
  output logic                          fan_off_o
);

  localparam int unsigned SUM_W = ADC_BITS +
      ((SAMPLES_PER_CHECK > 1) ? $clog2(SAMPLES_PER_CHECK) : 0);

  blri_pkg::cfg_t   cfg;
  logic             chk_valid, chk_ready;
  logic [SUM_W-1:0] chk_sum;

  blri_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  blri_accum #(
    .ADC_BITS          (ADC_BITS),
    .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK),
    .SUM_W             (SUM_W)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .adc_sample_i (adc_sample_i),
    .chk_valid_o  (chk_valid),
    .chk_ready_i  (chk_ready),
    .chk_sum_o    (chk_sum)
  );

  blri_level #(
    .ADC_BITS          (ADC_BITS),
    .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK),
    .SUM_W             (SUM_W)
  ) u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .chk_valid_i (chk_valid),
    .chk_ready_o (chk_ready),
    .chk_sum_i   (chk_sum),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o),
    .level_o     (level_o),
    .led_a_o     (led_a_o),
    .led_b_o     (led_b_o),
    .led_c_o     (led_c_o),
    .fan_off_o   (fan_off_o)
  );

endmodule

@@ src/blri_checker.sv @@
// Port-level checks for battery_level_ratchet_indicator_unit, bound to it below.
// Depends on blri_pkg.
module blri_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [blri_pkg::AVG_W-1:0] average_o,
  input logic [2:0]                 level_o,
  input logic                       led_a_o,
  input logic                       led_b_o,
  input logic                       led_c_o,
  input logic                       fan_off_o
);

  // level of the last delivered result, unknown after reset
  logic [2:0] last_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lvl_q <= blri_pkg::LVL_UNKNOWN;
    end else if (out_valid_o && out_ready_i) begin
      last_lvl_q <= level_o;
    end
  end

  // stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(average_o) &&
      $stable(level_o) && $stable({led_a_o, led_b_o, led_c_o, fan_off_o}))
    else $error("result changed while stalled");

  // the level never rises between transactions
  a_ratchet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= last_lvl_q)
    else $error("level rose");

  // dead band drives all LEDs and the fan-off latch
  a_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && level_o == blri_pkg::LVL_DEAD |->
      led_a_o && led_b_o && led_c_o && fan_off_o)
    else $error("dead band pattern wrong");

  // fan-off only ever comes with the dead band
  a_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fan_off_o |-> level_o == blri_pkg::LVL_DEAD)
    else $error("fan-off outside dead band");

endmodule

bind battery_level_ratchet_indicator_unit blri_checker u_blri_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for battery_level_ratchet_indicator_unit.
// Holds its own ratchet predictor and scoreboard; depends on blri_pkg and the RTL only.
module tb;

  localparam int unsigned CHECK_LEN   = 10;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned NUM_PHASES  = 9;

  // One check result as seen on the output channel
  typedef struct {
    logic [blri_pkg::AVG_W-1:0] average;
    blri_pkg::level_e           level;
    logic                       led_a;
    logic                       led_b;
    logic                       led_c;
    logic                       fan_off;
  } check_t;

  // Ratchet predictor plus the queue of checks still due from the block
  class ratchet_board;
    logic [blri_pkg::THR_W-1:0]   thr [5];
    logic [blri_pkg::FLASH_W-1:0] flash_limit;
    int unsigned                  sum;
    int unsigned                  count;
    blri_pkg::level_e             level;
    logic [2:0]                   leds;   // bit0 a, bit1 b, bit2 c
    logic                         fan;
    logic [blri_pkg::BLINK_W-1:0] blink;
    check_t                       due_checks [$];
    int unsigned                  n_samples;
    int unsigned                  n_checked;
    int unsigned                  n_errors;

    function new();
      thr[blri_pkg::REG_THR_TEN]     = blri_pkg::THR_TEN_RST;
      thr[blri_pkg::REG_THR_QUARTER] = blri_pkg::THR_QTR_RST;
      thr[blri_pkg::REG_THR_HALF]    = blri_pkg::THR_HALF_RST;
      thr[blri_pkg::REG_THR_3Q]      = blri_pkg::THR_3Q_RST;
      thr[blri_pkg::REG_THR_FULL]    = blri_pkg::THR_FULL_RST;
      flash_limit = blri_pkg::FLASH_LIM_RST;
      sum = 0;
      count = 0;
      level = blri_pkg::LVL_UNKNOWN;
      leds = '0;
      fan = 1'b0;
      blink = '0;
      n_samples = 0;
      n_checked = 0;
      n_errors = 0;
    endfunction

    function void set_reg(blri_pkg::reg_idx_e idx, logic [blri_pkg::DATA_W-1:0] v);
      if (idx == blri_pkg::REG_FLASH_LIMIT) flash_limit = v[blri_pkg::FLASH_W-1:0];
      else thr[int'(idx)] = v[blri_pkg::THR_W-1:0];
    endfunction

    // Priority order: full threshold first, down to ten; nothing reached is dead
    function blri_pkg::level_e band_of(int unsigned avg);
      if (avg >= thr[blri_pkg::REG_THR_FULL]) return blri_pkg::LVL_FULL;
      if (avg >= thr[blri_pkg::REG_THR_3Q]) return blri_pkg::LVL_3Q;
      if (avg >= thr[blri_pkg::REG_THR_HALF]) return blri_pkg::LVL_HALF;
      if (avg >= thr[blri_pkg::REG_THR_QUARTER]) return blri_pkg::LVL_QUARTER;
      if (avg >= thr[blri_pkg::REG_THR_TEN]) return blri_pkg::LVL_TEN;
      return blri_pkg::LVL_DEAD;
    endfunction

    // Called once per accepted input transaction
    function void note_sample(logic [11:0] s);
      check_t           c;
      int unsigned      avg;
      blri_pkg::level_e band;
      n_samples++;
      sum += s;
      count++;
      if (count < CHECK_LEN) return;
      avg = sum / CHECK_LEN;
      sum = 0;
      count = 0;

      // level only ratchets down
      band = band_of(avg);
      if (level > band) begin
        level = band;
        case (band) inside
          blri_pkg::LVL_FULL:                        leds = 3'b000;
          blri_pkg::LVL_3Q:                          leds = 3'b100;
          blri_pkg::LVL_HALF, blri_pkg::LVL_QUARTER: leds = 3'b110;
          blri_pkg::LVL_TEN:                         leds = {2'b11, leds[0]};
          default: begin
            leds = 3'b111;
            fan = 1'b1;
          end
        endcase
      end

      // blink pacing at ten percent; counter compared before increment
      if (level == blri_pkg::LVL_TEN) begin
        if (blink > blri_pkg::BLINK_W'(flash_limit)) begin
          leds[0] = ~leds[0];
          blink = '0;
        end else begin
          blink = blink + 1'b1;
        end
      end

      c.average = avg[blri_pkg::AVG_W-1:0];
      c.level   = level;
      c.led_a   = leds[0];
      c.led_b   = leds[1];
      c.led_c   = leds[2];
      c.fan_off = fan;
      due_checks.push_back(c);
    endfunction

    function void report(string msg);
      n_errors++;
      if (n_errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Called once per accepted output transaction
    function void check_result(check_t got);
      check_t want;
      if (due_checks.size() == 0) begin
        report($sformatf("result with none due: avg=%0d lvl=%0d", got.average, got.level));
        return;
      end
      want = due_checks.pop_front();
      n_checked++;
      if (got.average !== want.average || got.level !== want.level ||
          got.led_a !== want.led_a || got.led_b !== want.led_b ||
          got.led_c !== want.led_c || got.fan_off !== want.fan_off)
        report($sformatf({"check %0d expected avg=%0d lvl=%0d abc=%b%b%b fan=%b,",
                          " got avg=%0d lvl=%0d abc=%b%b%b fan=%b"},
                         n_checked, want.average, want.level, want.led_a, want.led_b,
                         want.led_c, want.fan_off, got.average, got.level, got.led_a,
                         got.led_b, got.led_c, got.fan_off));
    endfunction
  endclass

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [blri_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [blri_pkg::DATA_W-1:0]   pwdata       = '0;
  logic [blri_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic [11:0]                   adc_sample_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [blri_pkg::AVG_W-1:0]    average_o;
  logic [2:0]                    level_o;
  logic                          led_a_o;
  logic                          led_b_o;
  logic                          led_c_o;
  logic                          fan_off_o;

  ratchet_board                  sb = new();
  bit                            calm = 1'b1;
  blri_pkg::level_e              floor_band;
  int unsigned                   stuck = 0;
  int unsigned                   ready_hold = 0;
  logic [blri_pkg::DATA_W-1:0]   cfg_vals [6];
  bit [5:0]                      cfg_sel;

  battery_level_ratchet_indicator_unit DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones; none during calm phases
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One APB transfer: setup cycle, then access cycle; read data taken mid-access
  task automatic apb_xfer(input bit wr, input blri_pkg::reg_idx_e idx,
                          input logic [blri_pkg::DATA_W-1:0] wdata,
                          output logic [blri_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= blri_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
  endtask

  // Write the selected registers, read each one back, then release the bus
  task automatic reprogram();
    logic [blri_pkg::DATA_W-1:0] rd;
    logic [blri_pkg::DATA_W-1:0] mask;
    for (int i = 0; i < 6; i++) begin
      if (!cfg_sel[i]) continue;
      mask = (i == int'(blri_pkg::REG_FLASH_LIMIT)) ? (32'd1 << blri_pkg::FLASH_W) - 1 :
                                                     (32'd1 << blri_pkg::THR_W) - 1;
      apb_xfer(1'b1, blri_pkg::reg_idx_e'(i), cfg_vals[i], rd);
      apb_xfer(1'b0, blri_pkg::reg_idx_e'(i), '0, rd);
      sb.set_reg(blri_pkg::reg_idx_e'(i), cfg_vals[i]);
      if (rd !== (cfg_vals[i] & mask))
        sb.report($sformatf("register %0d read %0h, wrote %0h", i, rd, cfg_vals[i]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Input transaction; valid stays up across back-to-back samples
  task automatic send_sample(input logic [11:0] s, input int unsigned gap);
    in_valid_i   <= 1'b1;
    adc_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Block is idle once every due check has come back plus a latency margin
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_checks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: check accepted transactions, stall ready at random
  always @(posedge clk_i) begin
    check_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.average = average_o;
      got.level   = blri_pkg::level_e'(level_o);
      got.led_a   = led_a_o;
      got.led_b   = led_b_o;
      got.led_c   = led_c_o;
      got.fan_off = fan_off_o;
      sb.check_result(got);
    end
    if (ready_hold != 0) ready_hold--;
    else ready_hold = idle_len();
    out_ready_i <= (ready_hold == 0);
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned ladder [$];
    int unsigned lo;
    int unsigned hi;
    int unsigned n_checks;
    bit          narrow;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first check from unknown level, extremes and a floored sum -> full
    for (int i = 0; i < 9; i++) send_sample(12'hFFF, 0);
    send_sample(12'h000, 0);
    drain();

    // Directed: thresholds out of order, priority picks three quarter
    cfg_vals[blri_pkg::REG_THR_FULL] = 32'd4095;
    cfg_vals[blri_pkg::REG_THR_3Q]   = 32'd0;
    cfg_sel = '0;
    cfg_sel[blri_pkg::REG_THR_FULL] = 1'b1;
    cfg_sel[blri_pkg::REG_THR_3Q]   = 1'b1;
    reprogram();
    for (int i = 0; i < 10; i++) send_sample(i[0] ? 12'hFFF : 12'h000, 0);
    drain();

    // Random phases walk the level down one band at a time, dead last
    for (int p = 0; p < NUM_PHASES; p++) begin
      n_checks = 10;
      calm = (p == 2 || p == 5);
      cfg_sel = '1;
      ladder.delete();
      repeat (5) ladder.push_back($urandom_range(0, 4095));
      ladder.sort();
      foreach (ladder[i]) cfg_vals[i] = ladder[i];
      cfg_vals[blri_pkg::REG_FLASH_LIMIT] = $urandom_range(0, 20);
      case (p)
        0: begin
          // all thresholds zero: any average is full, level holds
          floor_band = blri_pkg::LVL_DEAD;
          for (int i = 0; i < 5; i++) cfg_vals[i] = 32'd0;
        end
        1: floor_band = blri_pkg::LVL_HALF;
        2: floor_band = blri_pkg::LVL_QUARTER;
        3: begin
          floor_band = blri_pkg::LVL_TEN;
          n_checks = 12;
          cfg_vals[blri_pkg::REG_THR_TEN]     = blri_pkg::THR_TEN_RST;
          cfg_vals[blri_pkg::REG_THR_QUARTER] = blri_pkg::THR_QTR_RST;
          cfg_vals[blri_pkg::REG_THR_HALF]    = blri_pkg::THR_HALF_RST;
          cfg_vals[blri_pkg::REG_THR_3Q]      = blri_pkg::THR_3Q_RST;
          cfg_vals[blri_pkg::REG_THR_FULL]    = blri_pkg::THR_FULL_RST;
          cfg_vals[blri_pkg::REG_FLASH_LIMIT] = 32'd0;
        end
        4: begin
          floor_band = blri_pkg::LVL_TEN;
          cfg_sel = '0;
          cfg_sel[blri_pkg::REG_FLASH_LIMIT] = 1'b1;
          cfg_vals[blri_pkg::REG_FLASH_LIMIT] = 32'd3;
        end
        5: begin
          // counter runs up under the largest limit
          floor_band = blri_pkg::LVL_TEN;
          cfg_sel = '0;
          cfg_sel[blri_pkg::REG_FLASH_LIMIT] = 1'b1;
          cfg_vals[blri_pkg::REG_FLASH_LIMIT] = 32'd65535;
        end
        6: begin
          // lowered limit: counter already past it toggles at the next check
          floor_band = blri_pkg::LVL_TEN;
          n_checks = 6;
          cfg_sel = '0;
          cfg_sel[blri_pkg::REG_FLASH_LIMIT] = 1'b1;
          cfg_vals[blri_pkg::REG_FLASH_LIMIT] = 32'd1;
        end
        7: begin
          floor_band = blri_pkg::LVL_DEAD;
          n_checks = 8;
          for (int i = 0; i < 5; i++) cfg_vals[i] = 32'd4095;
        end
        default: begin
          floor_band = blri_pkg::LVL_DEAD;
          n_checks = 8;
        end
      endcase
      reprogram();

      // Samples at or above the floor band's threshold; narrow checks stay in the band
      for (int k = 0; k < n_checks; k++) begin
        narrow = $urandom_range(0, 1);
        lo = 0;
        if (floor_band != blri_pkg::LVL_DEAD) lo = sb.thr[int'(floor_band) - 1];
        hi = 4095;
        if (narrow && floor_band != blri_pkg::LVL_FULL && sb.thr[int'(floor_band)] > lo)
          hi = sb.thr[int'(floor_band)] - 1;
        for (int j = 0; j < CHECK_LEN; j++)
          send_sample(12'($urandom_range(lo, hi)), idle_len());
      end
      drain();
    end

    $display("Covered %0d samples and %0d level checks over %0d setting phases; %0d errors.",
             sb.n_samples, sb.n_checked, NUM_PHASES + 2, sb.n_errors);
    if (sb.n_errors == 0 && sb.due_checks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
